// ----- rtl/lru_key_value_cache_core_macros.svh -----
// Shared assertion macros for the cache core checkers.
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LKVC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkvc: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define LKVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkvc: next-cycle check failed");

`endif

// ----- rtl/lkvc_pkg.sv -----
`default_nettype none

package lkvc_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int AGE_W    = IDX_W;
    localparam int LIVE_W   = $clog2(CAPACITY + 1);
    localparam int CFG_W    = 5;
    localparam int DATA_W   = 32;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = CFG_W'(CAPACITY);

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
    } t_resp;

endpackage

`default_nettype wire

// ----- rtl/lru_key_value_cache_core.sv -----
`default_nettype none

// LRU key-value cache core: 16-entry fully associative store. Pulse start
// while busy is low to transfer one command (get or put). For every command,
// one shared key comparator walks the sixteen entries one per cycle, picking
// up the key match, the oldest live entry and the first free slot; then come
// a compare-drain state and an update state. A get returns its result as a
// one-cycle o_done strobe in the cycle in which busy drops; the receiver
// cannot stall it and must take it in that cycle. A put returns nothing.
// max_entries may be written only while busy is low and no result is pending;
// valid marks clear at reset all at once.
module lru_key_value_cache_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    input  wire lkvc_pkg::t_req              i_req,
    input  wire                              i_cfg_we,
    input  wire  [lkvc_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic                             busy,
    output logic                             o_done,
    output lkvc_pkg::t_resp                  o_resp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    localparam int N  = lkvc_pkg::CAPACITY;
    localparam int IW = lkvc_pkg::IDX_W;
    localparam int AW = lkvc_pkg::AGE_W;
    localparam int LW = lkvc_pkg::LIVE_W;
    localparam int DW = lkvc_pkg::DATA_W;

    logic [1:0]                   r_state, n_state;
    logic [IW-1:0]                r_cnt;
    logic [lkvc_pkg::CFG_W-1:0]   r_max;
    logic [LW-1:0]                r_live;
    logic [N-1:0]                 r_valid, n_valid;
    logic [AW-1:0]                r_age [N];
    logic [AW-1:0]                n_age [N];

    logic                         r_cmd;
    logic [DW-1:0]                r_key;
    logic [DW-1:0]                r_val;

    logic [DW-1:0]                r_key_q;
    logic [IW-1:0]                r_q_idx;
    logic                         r_q_act;

    logic                         r_hit;
    logic [IW-1:0]                r_hit_idx;
    logic                         r_pick_vld;
    logic [IW-1:0]                r_pick_idx;
    logic [AW-1:0]                r_pick_age;
    logic                         r_free_vld;
    logic [IW-1:0]                r_free_idx;

    logic                         r_done;
    logic                         r_found;
    logic [DW-1:0]                r_rd_q;

    logic [DW-1:0]                m_key [N];
    logic [DW-1:0]                m_val [N];

    logic [LW-1:0]                w_limit;
    logic                         w_accept;
    logic                         w_match;
    logic                         w_evict;
    logic                         w_put_new;
    logic [IW-1:0]                w_slot;
    logic [AW-1:0]                w_touch_age;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_resp.found      = r_found;
    assign o_resp.read_value = r_found ? r_rd_q : '0;

    always_comb begin
        if (r_max == '0) begin
            w_limit = LW'(1);
        end else if (int'(r_max) > N) begin
            w_limit = LW'(N);
        end else begin
            w_limit = LW'(r_max);
        end
    end

    assign w_match   = r_q_act && r_valid[r_q_idx] && (r_key_q == r_key) && !r_hit;
    assign w_put_new = (r_cmd == lkvc_pkg::CMD_PUT) && !r_hit;
    assign w_evict   = w_put_new && (r_live >= w_limit);
    assign w_slot    = (r_free_vld && (!w_evict || (r_free_idx < r_pick_idx)))
                     ? r_free_idx : r_pick_idx;
    assign w_touch_age = r_age[r_hit_idx];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == IW'(N - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:   n_state = S_UPD;
            S_UPD:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        for (int i = 0; i < N; i++) begin
            n_age[i] = r_age[i];
        end
        if (r_state == S_UPD) begin
            if (r_hit) begin
                for (int i = 0; i < N; i++) begin
                    if (IW'(i) == r_hit_idx) begin
                        n_age[i] = '0;
                    end else if (r_valid[i] && (r_age[i] < w_touch_age)) begin
                        n_age[i] = r_age[i] + AW'(1);
                    end
                end
            end else if (w_put_new) begin
                for (int i = 0; i < N; i++) begin
                    if (IW'(i) == w_slot) begin
                        n_valid[i] = 1'b1;
                        n_age[i]   = '0;
                    end else if (w_evict && (IW'(i) == r_pick_idx)) begin
                        n_valid[i] = 1'b0;
                        n_age[i]   = '0;
                    end else if (r_valid[i]) begin
                        n_age[i] = r_age[i] + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_max      <= lkvc_pkg::MAX_ENTRIES_RST;
            r_live     <= '0;
            r_valid    <= '0;
            r_q_act    <= 1'b0;
            r_hit      <= 1'b0;
            r_pick_vld <= 1'b0;
            r_free_vld <= 1'b0;
            r_done     <= 1'b0;
            r_found    <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            for (int i = 0; i < N; i++) begin
                r_age[i] <= n_age[i];
            end
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            r_q_act <= (r_state == S_SCAN);
            r_done  <= (r_state == S_UPD) && (r_cmd == lkvc_pkg::CMD_GET);

            if (w_accept) begin
                r_cnt      <= '0;
                r_hit      <= 1'b0;
                r_pick_vld <= 1'b0;
                r_free_vld <= 1'b0;
            end

            if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + IW'(1);
                if (r_valid[r_cnt] && (!r_pick_vld || (r_age[r_cnt] > r_pick_age))) begin
                    r_pick_vld <= 1'b1;
                end
                if (!r_valid[r_cnt] && !r_free_vld) begin
                    r_free_vld <= 1'b1;
                end
            end

            if (w_match) begin
                r_hit <= 1'b1;
            end

            if (r_state == S_UPD) begin
                r_found <= r_hit;
                if (w_put_new && !w_evict) begin
                    r_live <= r_live + LW'(1);
                end
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_req.command;
            r_key <= i_req.key;
            r_val <= i_req.value;
        end
        r_q_idx <= r_cnt;
        if (w_match) begin
            r_hit_idx <= r_q_idx;
        end
        if (r_state == S_SCAN) begin
            if (r_valid[r_cnt] && (!r_pick_vld || (r_age[r_cnt] > r_pick_age))) begin
                r_pick_idx <= r_cnt;
                r_pick_age <= r_age[r_cnt];
            end
            if (!r_valid[r_cnt] && !r_free_vld) begin
                r_free_idx <= r_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_key_q <= m_key[r_cnt];
        end
        if ((r_state == S_UPD) && w_put_new) begin
            m_key[w_slot] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_rd_q <= m_val[r_hit_idx];
            if (r_cmd == lkvc_pkg::CMD_PUT) begin
                m_val[r_hit ? r_hit_idx : w_slot] <= r_val;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lkvc_checker.sv -----
`default_nettype none

`include "lru_key_value_cache_core_macros.svh"

module lkvc_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              start,
    input wire lkvc_pkg::t_req              i_req,
    input wire                              i_cfg_we,
    input wire  [lkvc_pkg::CFG_W-1:0]       i_cfg_wdata,
    input wire                              busy,
    input wire                              o_done,
    input wire lkvc_pkg::t_resp             o_resp
);

    logic w_unused;
    assign w_unused = ^{i_req, i_cfg_we, i_cfg_wdata};

    `LKVC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `LKVC_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `LKVC_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `LKVC_ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n, o_done && !o_resp.found, o_resp.read_value == '0)

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .i_req       (i_req),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_wdata (i_cfg_wdata),
    .busy        (busy),
    .o_done      (o_done),
    .o_resp      (o_resp)
);

`default_nettype wire

// ----- tb/lru_key_value_cache_core_tb.sv -----
`timescale 1ns / 1ps

module lru_key_value_cache_core_tb;
    import lkvc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_SETTLE    = 24;
    localparam int PHASE_ITEMS    = 115;
    localparam int NUM_PHASES     = 10;

    localparam logic [DATA_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    t_req               i_req       = '0;
    logic               i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;
    logic               busy;
    logic               o_done;
    t_resp              o_resp;

    // shadow copy of the cache contents and recency ranks
    logic [DATA_W-1:0]  shadow_key   [CAPACITY];
    logic [DATA_W-1:0]  shadow_value [CAPACITY];
    bit                 shadow_valid [CAPACITY];
    int                 shadow_age   [CAPACITY];
    int                 shadow_live;
    logic [CFG_W-1:0]   shadow_limit;

    t_resp              lookup_q[$];
    int                 mismatch_count = 0;
    int                 burst_left     = 0;
    int                 idle_cycles    = 0;

    always #5 i_clk = ~i_clk;

    lru_key_value_cache_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .busy        (busy),
        .o_done      (o_done),
        .o_resp      (o_resp)
    );

    function automatic t_req make_req(input logic cmd, input logic [DATA_W-1:0] k,
                                      input logic [DATA_W-1:0] v);
        t_req r;
        r.command = cmd;
        r.key     = k;
        r.value   = v;
        return r;
    endfunction

    // make an entry most recent: every younger live entry ages by one
    function automatic void promote_entry(input int slot);
        int rank;
        rank = shadow_age[slot];
        for (int i = 0; i < CAPACITY; i++)
            if (shadow_valid[i] && shadow_age[i] < rank)
                shadow_age[i]++;
        shadow_age[slot] = 0;
    endfunction

    function automatic void cache_predict(input t_req r);
        int    hit;
        int    oldest;
        int    slot;
        int    lim;
        t_resp resp;
        hit = -1;
        for (int i = 0; i < CAPACITY; i++)
            if (hit < 0 && shadow_valid[i] && shadow_key[i] == r.key)
                hit = i;
        if (r.command == CMD_GET) begin
            resp = '0;
            if (hit >= 0) begin
                promote_entry(hit);
                resp.found      = 1'b1;
                resp.read_value = shadow_value[hit];
            end
            lookup_q.push_back(resp);
        end else if (hit >= 0) begin
            shadow_value[hit] = r.value;
            promote_entry(hit);
        end else begin
            lim = (shadow_limit == 0) ? 1
                : ((shadow_limit > CAPACITY) ? CAPACITY : shadow_limit);
            if (shadow_live >= lim) begin
                oldest = -1;
                for (int i = 0; i < CAPACITY; i++)
                    if (shadow_valid[i] && (oldest < 0 || shadow_age[i] > shadow_age[oldest]))
                        oldest = i;
                if (oldest >= 0) begin
                    shadow_valid[oldest] = 1'b0;
                    shadow_age[oldest]   = 0;
                    shadow_live--;
                end
            end
            slot = -1;
            for (int i = 0; i < CAPACITY; i++)
                if (slot < 0 && !shadow_valid[i])
                    slot = i;
            if (slot >= 0) begin
                for (int i = 0; i < CAPACITY; i++)
                    if (shadow_valid[i])
                        shadow_age[i]++;
                shadow_key[slot]   = r.key;
                shadow_value[slot] = r.value;
                shadow_valid[slot] = 1'b1;
                shadow_age[slot]   = 0;
                shadow_live++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin : check_result
            t_resp want;
            if (lookup_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: found=%0b read_value=%0d",
                             o_resp.found, o_resp.read_value);
            end else begin
                want = lookup_q.pop_front();
                if (o_resp.found !== want.found || o_resp.read_value !== want.read_value) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: want found=%0b value=%0d, got found=%0b value=%0d",
                                 want.found, want.read_value, o_resp.found, o_resp.read_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // transfer one command; bursts of random length with random gaps between
    task automatic send_req(input t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        cache_predict(r);
        @(negedge i_clk);
    endtask

    // drop start, wait for every lookup result and let a trailing put finish
    task automatic settle_idle();
        start <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (lookup_q.size() != 0 || busy);
        repeat (IDLE_SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        settle_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_limit = v;
    endtask

    task automatic test_empty_miss();
        send_req(make_req(CMD_GET, '0, KEY_MAX));
        send_req(make_req(CMD_GET, KEY_MIN, '0));
    endtask

    task automatic test_extreme_fields();
        send_req(make_req(CMD_PUT, KEY_MIN, KEY_MAX));
        send_req(make_req(CMD_PUT, KEY_MAX, KEY_MIN));
        send_req(make_req(CMD_PUT, '0, '0));
        send_req(make_req(CMD_PUT, '1, '1));
        send_req(make_req(CMD_GET, KEY_MIN, '0));
        send_req(make_req(CMD_GET, KEY_MAX, '1));
        send_req(make_req(CMD_GET, '0, '0));
        send_req(make_req(CMD_GET, '1, '0));
        send_req(make_req(CMD_PUT, '0, 32'h5A5A_5A5A));
        send_req(make_req(CMD_GET, '0, '0));
    endtask

    // a limit of zero acts as one and the limit sits below the live count
    task automatic test_limit_zero();
        write_limit('0);
        send_req(make_req(CMD_PUT, 32'd7, 32'd1));
        send_req(make_req(CMD_GET, KEY_MIN, '0));
        send_req(make_req(CMD_GET, 32'd7, '0));
    endtask

    // a limit above capacity acts as capacity
    task automatic test_limit_over();
        write_limit('1);
        send_req(make_req(CMD_PUT, 32'd8, 32'hDEAD_BEEF));
        send_req(make_req(CMD_GET, 32'd8, '0));
        send_req(make_req(CMD_GET, '1, '0));
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0]  limits [NUM_PHASES];
        logic [DATA_W-1:0] key_pool [$];
        logic [DATA_W-1:0] k;
        logic [DATA_W-1:0] v;
        int                eff;
        limits = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd2, 5'd15, 5'd0, 5'd0, 5'd0};
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p >= 7)
                limits[p] = $urandom_range(0, 31);
            write_limit(limits[p]);
            eff = (limits[p] == 0) ? 1 : ((limits[p] > CAPACITY) ? CAPACITY : limits[p]);
            key_pool.delete();
            repeat (eff + $urandom_range(0, 6)) key_pool.push_back($urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) == 0)
                    k = $urandom;
                else
                    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                if ($urandom_range(0, 7) == 0)
                    v = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
                else
                    v = $urandom;
                send_req(make_req($urandom_range(0, 1) ? CMD_PUT : CMD_GET, k, v));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < CAPACITY; i++) begin
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_valid[i] = 1'b0;
            shadow_age[i]   = 0;
        end
        shadow_live  = 0;
        shadow_limit = MAX_ENTRIES_RST;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_empty_miss();
        test_extreme_fields();
        test_limit_zero();
        test_limit_over();
        test_random_phases();
        settle_idle();
        if (mismatch_count == 0 && lookup_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
